### design/decimal_fixed_mul_div_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the decimal fixed-point multiply/divide unit
// Shared implication and invariant checks clocked on the rising edge.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_FIXED_MUL_DIV_MACROS_SVH
`define DECIMAL_FIXED_MUL_DIV_MACROS_SVH

// check that ante implies cons in the same cycle
`define DFMD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check that ante implies cons in the next cycle
`define DFMD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/dfmd_pkg.sv
// ----------------------------------------------------------------------------
// dfmd_pkg
// Constants and helper functions for the decimal fixed-point mul/div unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dfmd_pkg;

    localparam int FRACTION_DIGITS_DEF = 4;
    localparam int DIGIT_LIMIT         = 9;
    localparam logic [31:0] RECIP10    = 32'hCCCC_CCCD;
    localparam logic CMD_MUL           = 1'b0;
    localparam logic CMD_DIV           = 1'b1;

    function automatic logic [31:0] pow10(input int n);
        logic [31:0] p;
        p = 32'd1;
        for (int i = 0; i < n; i++)
        begin
            p = 32'(p * 32'd10);
        end
        return p;
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] x);
        logic [31:0] m;
        m = x[31] ? 32'(~x + 32'd1) : 32'(x);
        return m;
    endfunction

    function automatic logic signed [4:0] digits_less_one(input logic signed [31:0] x);
        logic [31:0] m;
        logic [4:0]  n;
        m = mag32(x);
        n = 5'd0;
        for (int k = 0; k < 10; k++)
        begin
            if (m >= pow10(k))
            begin
                n = 5'(n + 5'd1);
            end
        end
        return $signed(5'(n - 5'd1));
    endfunction

endpackage

`default_nettype wire

### design/decimal_fixed_mul_div.sv
// ----------------------------------------------------------------------------
// decimal_fixed_mul_div
// Signed 32-bit decimal fixed-point multiply and divide, one transaction at
// a time, built around one shared 32x32 multiplier and a bit-serial divider.
// ----------------------------------------------------------------------------
// A transaction is accepted only while in_stall is low, and in_stall stays
// high until the result is taken. A divide by zero reaches out_valid in the
// cycle after acceptance. A multiply runs a digit-count step, one truncation
// step per dropped operand digit, one step to leave truncation, one product
// step, one step per rescaling digit and one step to finish.
// A divide runs the restoring divider and one product step, and stops there
// when the operands are equal; otherwise the remainder multiply sequence
// follows, and a nonzero remainder adds the fraction digit steps, a second
// divide and its rescaling. The shared multiplier also performs every
// divide by ten.
`timescale 1ns / 1ps
`default_nettype none
`include "decimal_fixed_mul_div_macros.svh"

module decimal_fixed_mul_div #(
    parameter int FRACTION_DIGITS = dfmd_pkg::FRACTION_DIGITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               cmd,
    input  wire logic signed [31:0] operand_a,
    input  wire logic signed [31:0] operand_b,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      result
);
    import dfmd_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_DIGITS  = 8'b0000_0010,
        S_TRUNC_X = 8'b0000_0100,
        S_TRUNC_Y = 8'b0000_1000,
        S_MUL     = 8'b0001_0000,
        S_SCALE   = 8'b0010_0000,
        S_DIVIDE  = 8'b0100_0000,
        S_DONE    = 8'b1000_0000
    } state_t;

    typedef enum logic [1:0] {
        PH_MUL,
        PH_WHOLE,
        PH_REM,
        PH_FRAC
    } phase_t;

    localparam logic [31:0]        UNIT      = pow10(FRACTION_DIGITS);
    localparam logic signed [5:0]  MUL_SCALE = 6'(2 * FRACTION_DIGITS);
    localparam logic signed [5:0]  MUL_TGT   = 6'(FRACTION_DIGITS);
    localparam logic [3:0]         LIM_MUL   = 4'(DIGIT_LIMIT - 1);
    localparam logic [3:0]         LIM_DIV   = 4'(DIGIT_LIMIT);

    state_t                state_reg, state_next;
    phase_t                phase_reg, phase_next;
    logic signed [31:0]    a_reg, a_next, b_reg, b_next;
    logic signed [31:0]    x_reg, x_next, y_reg, y_next;
    logic signed [4:0]     dx_reg, dx_next, dy_reg, dy_next;
    logic signed [5:0]     scale_reg, scale_next, tgt_reg, tgt_next;
    logic [3:0]            limit_reg, limit_next;
    logic signed [31:0]    res_reg, res_next, whole_reg, whole_next;
    logic signed [31:0]    result_reg, result_next;
    logic [31:0]           div_r_reg, div_r_next, div_q_reg, div_q_next;
    logic [31:0]           div_d_reg, div_d_next;
    logic                  div_neg_reg, div_neg_next;
    logic [4:0]            div_cnt_reg, div_cnt_next;

    logic signed [5:0]     digit_sum;
    logic                  trunc_cond;
    logic signed [31:0]    d10_src, d10_res, times10, prod_lo, quot, rem_val;
    logic [31:0]           d10_mag, mul_a, mul_b, d10_q, q_shift;
    logic [63:0]           prod;
    logic [32:0]           r_shift;
    logic [33:0]           r_diff;
    logic                  r_ge;
    logic                  div_zero_fire, div_zero_ok, mul_fire;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_DONE);
    assign result    = result_reg;

    assign digit_sum  = 6'(dx_reg) + 6'(dy_reg);
    assign trunc_cond = (digit_sum >= $signed({2'b00, limit_reg}));

    always_comb
    begin
        case (state_reg)
            S_TRUNC_X: d10_src = x_reg;
            S_TRUNC_Y: d10_src = y_reg;
            default:   d10_src = res_reg;
        endcase
    end

    assign d10_mag = mag32(d10_src);
    assign mul_a   = (state_reg == S_MUL) ? x_reg : d10_mag;
    assign mul_b   = (state_reg == S_MUL) ? y_reg : RECIP10;
    assign prod    = 64'(mul_a) * 64'(mul_b);
    assign prod_lo = prod[31:0];
    assign d10_q   = 32'(prod >> 35);
    assign d10_res = d10_src[31] ? 32'(-d10_q) : d10_q;
    assign times10 = 32'((res_reg <<< 3) + (res_reg <<< 1));
    assign rem_val = 32'(a_reg - res_reg);

    assign r_shift = {div_r_reg, div_q_reg[31]};
    assign r_diff  = {1'b0, r_shift} - {2'b00, div_d_reg};
    assign r_ge    = !r_diff[33];
    assign q_shift = {div_q_reg[30:0], r_ge};
    assign quot    = div_neg_reg ? 32'(-q_shift) : q_shift;

    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        scale_next   = scale_reg;
        tgt_next     = tgt_reg;
        limit_next   = limit_reg;
        res_next     = res_reg;
        whole_next   = whole_reg;
        result_next  = result_reg;
        div_r_next   = div_r_reg;
        div_q_next   = div_q_reg;
        div_d_next   = div_d_reg;
        div_neg_next = div_neg_reg;
        div_cnt_next = div_cnt_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    a_next = operand_a;
                    b_next = operand_b;
                    if (cmd == CMD_MUL)
                    begin
                        x_next     = operand_a;
                        y_next     = operand_b;
                        scale_next = MUL_SCALE;
                        tgt_next   = MUL_TGT;
                        limit_next = LIM_MUL;
                        phase_next = PH_MUL;
                        state_next = S_DIGITS;
                    end
                    else if (operand_b == 32'sd0)
                    begin
                        result_next = '1;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        div_r_next   = '0;
                        div_q_next   = mag32(operand_a);
                        div_d_next   = mag32(operand_b);
                        div_neg_next = operand_a[31] ^ operand_b[31];
                        div_cnt_next = '0;
                        phase_next   = PH_WHOLE;
                        state_next   = S_DIVIDE;
                    end
                end
            end
            S_DIGITS:
            begin
                dx_next    = digits_less_one(x_reg);
                dy_next    = digits_less_one(y_reg);
                state_next = S_TRUNC_X;
            end
            S_TRUNC_X:
            begin
                if (trunc_cond)
                begin
                    x_next     = d10_res;
                    dx_next    = 5'(dx_reg - 5'sd1);
                    scale_next = 6'(scale_reg - 6'sd1);
                    state_next = S_TRUNC_Y;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_TRUNC_Y:
            begin
                if (trunc_cond)
                begin
                    y_next     = d10_res;
                    dy_next    = 5'(dy_reg - 5'sd1);
                    scale_next = 6'(scale_reg - 6'sd1);
                    state_next = S_TRUNC_X;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                case (phase_reg)
                    PH_WHOLE:
                    begin
                        whole_next = prod_lo;
                        if (a_reg == b_reg)
                        begin
                            result_next = prod_lo;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            x_next     = prod_lo;
                            y_next     = b_reg;
                            scale_next = MUL_SCALE;
                            tgt_next   = MUL_TGT;
                            limit_next = LIM_MUL;
                            phase_next = PH_REM;
                            state_next = S_DIGITS;
                        end
                    end
                    PH_FRAC:
                    begin
                        div_r_next   = '0;
                        div_q_next   = mag32(prod_lo);
                        div_d_next   = mag32(b_reg);
                        div_neg_next = prod_lo[31] ^ b_reg[31];
                        div_cnt_next = '0;
                        state_next   = S_DIVIDE;
                    end
                    default:
                    begin
                        res_next   = prod_lo;
                        state_next = S_SCALE;
                    end
                endcase
            end
            S_SCALE:
            begin
                if (scale_reg > tgt_reg)
                begin
                    res_next   = d10_res;
                    scale_next = 6'(scale_reg - 6'sd1);
                end
                else if (scale_reg < tgt_reg)
                begin
                    res_next   = times10;
                    scale_next = 6'(scale_reg + 6'sd1);
                end
                else
                begin
                    case (phase_reg)
                        PH_REM:
                        begin
                            if (rem_val == 32'sd0)
                            begin
                                result_next = whole_reg;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                x_next     = UNIT;
                                y_next     = rem_val;
                                scale_next = '0;
                                tgt_next   = '0;
                                limit_next = LIM_DIV;
                                phase_next = PH_FRAC;
                                state_next = S_DIGITS;
                            end
                        end
                        PH_FRAC:
                        begin
                            result_next = 32'(res_reg + whole_reg);
                            state_next  = S_DONE;
                        end
                        default:
                        begin
                            result_next = res_reg;
                            state_next  = S_DONE;
                        end
                    endcase
                end
            end
            S_DIVIDE:
            begin
                div_r_next   = r_ge ? r_diff[31:0] : r_shift[31:0];
                div_q_next   = q_shift;
                div_cnt_next = 5'(div_cnt_reg + 5'd1);
                if (div_cnt_reg == 5'd31)
                begin
                    if (phase_reg == PH_WHOLE)
                    begin
                        x_next     = quot;
                        y_next     = UNIT;
                        state_next = S_MUL;
                    end
                    else
                    begin
                        res_next   = quot;
                        state_next = S_SCALE;
                    end
                end
            end
            S_DONE:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_MUL;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg       <= a_next;
        b_reg       <= b_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        scale_reg   <= scale_next;
        tgt_reg     <= tgt_next;
        limit_reg   <= limit_next;
        res_reg     <= res_next;
        whole_reg   <= whole_next;
        result_reg  <= result_next;
        div_r_reg   <= div_r_next;
        div_q_reg   <= div_q_next;
        div_d_reg   <= div_d_next;
        div_neg_reg <= div_neg_next;
        div_cnt_reg <= div_cnt_next;
    end

    assign div_zero_fire = in_valid && !in_stall && (cmd == CMD_DIV) && (operand_b == 32'sd0);
    assign div_zero_ok   = out_valid && (result == -32'sd1);
    assign mul_fire      = in_valid && !in_stall && (cmd == CMD_MUL);

    `DFMD_ASSERT_IMP(a_busy_while_out, clk, rst_n, out_valid, in_stall, "valid while idle")
    `DFMD_ASSERT_NEXT(a_div_zero, clk, rst_n, div_zero_fire, div_zero_ok, "div by zero result")
    `DFMD_ASSERT_NEXT(a_mul_start, clk, rst_n, mul_fire, state_reg == S_DIGITS, "no digit count")

endmodule

`default_nettype wire
